// ===== src/npm_pkg.sv =====
// Shared types, constants and modular helpers for the NTT polynomial multiplier.
package npm_pkg;

	localparam int N_COEFFS = 256;
	localparam int ADDR_W   = 8;
	localparam int COEFF_W  = 23;
	localparam int KIND_W   = 3;

	localparam logic [COEFF_W-1:0] MOD_Q      = 23'd8380417;
	localparam logic [COEFF_W-1:0] ROOT       = 23'd1753;
	localparam logic [COEFF_W-1:0] INV_DEGREE = 23'd8347681;

	// command kinds; codes 5..7 are no-ops
	typedef enum logic [KIND_W-1:0] {
		K_WRITE_A  = 3'd0,
		K_WRITE_B  = 3'd1,
		K_FWD_NTT  = 3'd2,
		K_INV_NTT  = 3'd3,
		K_POLY_MUL = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_START, PH_COPY, PH_FWD_T, PH_FWD_A, PH_POINT, PH_INV, PH_SCALE, PH_DONE
	} phase_t;

	typedef enum logic [4:0] {
		ST_INIT_WR, ST_WAIT, ST_INIT_LD, ST_IDLE, ST_WRITE, ST_DISPATCH,
		ST_CP_RD, ST_CP_WR, ST_BF_RD0, ST_BF_RD1, ST_BF_RD2, ST_BF_MUL,
		ST_BF_WR0, ST_BF_WR1, ST_EL_RD, ST_EL_CAP, ST_EL_MUL, ST_EL_WR,
		ST_RD, ST_CAP
	} state_t;

	typedef enum logic [2:0] {
		MUL_FWD, MUL_INV, MUL_POINT, MUL_SCALE, MUL_TWID
	} mul_op_t;

	typedef enum logic [2:0] {
		WS_COEFF, WS_COPY, WS_ADD_XY, WS_ADD_XR, WS_SUB_XR, WS_PROD
	} wsrc_t;

	typedef struct packed {
		logic              cap_in;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] z_addr;
		logic              a_we;
		logic              b_we;
		logic              t_we;
		logic              z_we;
		wsrc_t             wsrc;
		logic              use_t;
		logic              cap_x;
		logic              cap_y;
		logic              cap_pair;
		logic              cap_z;
		logic              neg_z;
		mul_op_t           mul_op;
		logic              cap_r;
		logic              pw_load;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	function automatic logic [COEFF_W-1:0] mod_add(input logic [COEFF_W-1:0] a,
		input logic [COEFF_W-1:0] b);
		logic [COEFF_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, MOD_Q}) ? COEFF_W'(s - {1'b0, MOD_Q}) : s[COEFF_W-1:0];
	endfunction

	function automatic logic [COEFF_W-1:0] mod_sub(input logic [COEFF_W-1:0] a,
		input logic [COEFF_W-1:0] b);
		return (a >= b) ? COEFF_W'(a - b) : COEFF_W'({1'b0, a} + {1'b0, MOD_Q} - {1'b0, b});
	endfunction

	function automatic logic [ADDR_W-1:0] bitrev8(input logic [ADDR_W-1:0] k);
		logic [ADDR_W-1:0] r;
		for (int i = 0; i < ADDR_W; i++) begin
			r[i] = k[ADDR_W-1-i];
		end
		return r;
	endfunction

	// phase that follows ph for a given command
	function automatic phase_t next_phase(input kind_t k, input phase_t ph);
		phase_t n;
		n = PH_DONE;
		if (k == K_FWD_NTT) begin
			n = (ph == PH_START) ? PH_FWD_A : PH_DONE;
		end else if (k == K_INV_NTT) begin
			n = (ph == PH_START) ? PH_INV : ((ph == PH_INV) ? PH_SCALE : PH_DONE);
		end else if (k == K_POLY_MUL) begin
			unique case (ph)
				PH_START: n = PH_COPY;
				PH_COPY:  n = PH_FWD_T;
				PH_FWD_T: n = PH_FWD_A;
				PH_FWD_A: n = PH_POINT;
				PH_POINT: n = PH_INV;
				PH_INV:   n = PH_SCALE;
				default:  n = PH_DONE;
			endcase
		end
		return n;
	endfunction

endpackage

// ===== src/npm_in_if.sv =====
// Command channel: kind, index, coefficient and read request.
interface npm_in_if;
	logic                           valid;
	logic                           ready;
	logic [npm_pkg::KIND_W-1:0]     kind;
	logic [npm_pkg::ADDR_W-1:0]     index;
	logic [npm_pkg::COEFF_W-1:0]    coeff;
	logic                           want_read;

	modport source(output valid, kind, index, coeff, want_read, input ready);
	modport sink(input valid, kind, index, coeff, want_read, output ready);
endinterface

// ===== src/npm_out_if.sv =====
// Result channel: one read-back coefficient of A.
interface npm_out_if;
	logic                        valid;
	logic                        ready;
	logic [npm_pkg::COEFF_W-1:0] read_value;

	modport source(output valid, read_value, input ready);
	modport sink(input valid, read_value, output ready);
endinterface

// ===== src/npm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module npm_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/npm_modmul.sv =====
// Four-stage multiplier mod q, using 2^23 = 2^13 - 1 (mod q) folding.
module npm_modmul (
	input  logic                        clk,
	input  logic [npm_pkg::COEFF_W-1:0] a,
	input  logic [npm_pkg::COEFF_W-1:0] b,
	output logic [npm_pkg::COEFF_W-1:0] r
);
	import npm_pkg::*;

	logic [45:0] p_s1;
	logic [36:0] f_s2;
	logic [27:0] f_s3;
	logic [22:0] r_s4;
	logic [22:0] hi2;
	logic [13:0] hi3;
	logic [4:0]  hi4;
	logic [23:0] f4;

	assign hi2 = p_s1[45:23];
	assign hi3 = f_s2[36:23];
	assign hi4 = f_s3[27:23];
	assign f4  = 24'({hi4, 13'b0}) - 24'(hi4) + 24'(f_s3[22:0]);

	always_ff @(posedge clk) begin
		p_s1 <= 46'(a) * 46'(b);
		f_s2 <= 37'({hi2, 13'b0}) - 37'(hi2) + 37'(p_s1[22:0]);
		f_s3 <= 28'({hi3, 13'b0}) - 28'(hi3) + 28'(f_s2[22:0]);
		r_s4 <= (f4 >= {1'b0, MOD_Q}) ? COEFF_W'(f4 - {1'b0, MOD_Q}) : f4[22:0];
	end

	assign r = r_s4;
endmodule

// ===== src/npm_datapath.sv =====
// Datapath: coefficient RAMs, twiddle RAM, butterfly operands and output register.
module npm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npm_pkg::dp_cmd_t            cmd,
	output npm_pkg::dp_sts_t            sts,
	input  logic [npm_pkg::COEFF_W-1:0] in_coeff,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [npm_pkg::COEFF_W-1:0] out_value
);
	import npm_pkg::*;

	logic [COEFF_W-1:0] a_rd, b_rd, t_rd, z_rd, work_rd, wd;
	logic [COEFF_W-1:0] coeff_q, x_q, y_q, z_q, r_q, pw_q, out_q;
	logic [COEFF_W-1:0] mul_a, mul_b, mul_r;
	logic               out_valid_q;

	npm_ram #(.WIDTH(COEFF_W), .DEPTH(N_COEFFS)) u_ram_a (
		.clk(clk), .we(cmd.a_we), .waddr(cmd.addr), .wdata(wd),
		.raddr(cmd.addr), .rdata(a_rd));
	npm_ram #(.WIDTH(COEFF_W), .DEPTH(N_COEFFS)) u_ram_b (
		.clk(clk), .we(cmd.b_we), .waddr(cmd.addr), .wdata(coeff_q),
		.raddr(cmd.addr), .rdata(b_rd));
	npm_ram #(.WIDTH(COEFF_W), .DEPTH(N_COEFFS)) u_ram_t (
		.clk(clk), .we(cmd.t_we), .waddr(cmd.addr), .wdata(wd),
		.raddr(cmd.addr), .rdata(t_rd));
	npm_ram #(.WIDTH(COEFF_W), .DEPTH(N_COEFFS)) u_ram_z (
		.clk(clk), .we(cmd.z_we), .waddr(cmd.z_addr), .wdata(pw_q),
		.raddr(cmd.z_addr), .rdata(z_rd));

	npm_modmul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .r(mul_r));

	assign work_rd = cmd.use_t ? t_rd : a_rd;

	// multiplier operand select
	always_comb begin
		unique case (cmd.mul_op)
			MUL_FWD:   begin mul_a = z_q;  mul_b = y_q; end
			MUL_INV:   begin mul_a = z_q;  mul_b = mod_sub(x_q, y_q); end
			MUL_POINT: begin mul_a = x_q;  mul_b = y_q; end
			MUL_SCALE: begin mul_a = x_q;  mul_b = INV_DEGREE; end
			MUL_TWID:  begin mul_a = pw_q; mul_b = ROOT; end
			default:   begin mul_a = x_q;  mul_b = y_q; end
		endcase
	end

	// write data select
	always_comb begin
		unique case (cmd.wsrc)
			WS_COEFF:  wd = coeff_q;
			WS_COPY:   wd = b_rd;
			WS_ADD_XY: wd = mod_add(x_q, y_q);
			WS_ADD_XR: wd = mod_add(x_q, r_q);
			WS_SUB_XR: wd = mod_sub(x_q, r_q);
			WS_PROD:   wd = r_q;
			default:   wd = coeff_q;
		endcase
	end

	// operand holding registers
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			coeff_q <= (in_coeff >= MOD_Q) ? COEFF_W'(in_coeff - MOD_Q) : in_coeff;
		end
		if (cmd.cap_x) begin
			x_q <= work_rd;
		end else if (cmd.cap_pair) begin
			x_q <= a_rd;
		end
		if (cmd.cap_y) begin
			y_q <= work_rd;
		end else if (cmd.cap_pair) begin
			y_q <= t_rd;
		end
		if (cmd.cap_z) begin
			z_q <= cmd.neg_z ? COEFF_W'(MOD_Q - z_rd) : z_rd;
		end
		if (cmd.cap_r) begin
			r_q <= mul_r;
		end
		if (cmd.out_load) begin
			out_q <= a_rd;
		end
	end

	// running power of the root for the twiddle sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= COEFF_W'(1);
		end else if (cmd.pw_load) begin
			pw_q <= r_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_value    = out_q;
endmodule

// ===== src/npm_ctrl.sv =====
// Controller: command sequencing, NTT layer/butterfly counters and RAM addressing.
module npm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [npm_pkg::KIND_W-1:0]  in_kind,
	input  logic [npm_pkg::ADDR_W-1:0]  in_index,
	input  logic                        in_want,
	input  npm_pkg::dp_sts_t            sts,
	output npm_pkg::dp_cmd_t            cmd
);
	import npm_pkg::*;

	state_t            state_q, state_d;
	phase_t            phase_q;
	kind_t             kind_q;
	logic [ADDR_W-1:0] idx_q;
	logic              want_q;
	logic [2:0]        lyr_q;
	logic [6:0]        bf_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [1:0]        wait_q;

	logic              fwd, bf_last, cnt_last;
	logic [2:0]        lg;
	logic [ADDR_W-1:0] bx, grp, lo_mask, j_lo, j_hi, m_fwd, m_idx;
	logic [ADDR_W:0]   m_inv;

	// butterfly address generation
	assign fwd      = (phase_q != PH_INV);
	assign lg       = fwd ? 3'(3'd7 - lyr_q) : lyr_q;
	assign bx       = {1'b0, bf_q};
	assign grp      = bx >> lg;
	assign lo_mask  = (ADDR_W'(1) << lg) - ADDR_W'(1);
	assign j_lo     = (grp << ({1'b0, lg} + 4'd1)) | (bx & lo_mask);
	assign j_hi     = j_lo | (ADDR_W'(1) << lg);
	assign m_fwd    = (ADDR_W'(1) << lyr_q) + grp;
	assign m_inv    = (9'd256 >> lyr_q) - 9'd1 - {1'b0, grp};
	assign m_idx    = fwd ? m_fwd : m_inv[ADDR_W-1:0];
	assign bf_last  = (bf_q == 7'd127) && (lyr_q == 3'd7);
	assign cnt_last = (cnt_q == ADDR_W'(N_COEFFS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT_WR: state_d = ST_WAIT;
			ST_WAIT: begin
				if (wait_q == 2'd3) begin
					unique case (phase_q)
						PH_START:                   state_d = ST_INIT_LD;
						PH_FWD_T, PH_FWD_A, PH_INV: state_d = ST_BF_WR0;
						PH_POINT, PH_SCALE:         state_d = ST_EL_WR;
						default:                    state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT_LD: state_d = cnt_last ? ST_IDLE : ST_INIT_WR;
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_kind == K_WRITE_A || in_kind == K_WRITE_B) ?
						ST_WRITE : ST_DISPATCH;
				end
			end
			ST_WRITE: state_d = want_q ? ST_RD : ST_IDLE;
			ST_DISPATCH: begin
				unique case (phase_q)
					PH_COPY:                    state_d = ST_CP_RD;
					PH_FWD_T, PH_FWD_A, PH_INV: state_d = ST_BF_RD0;
					PH_POINT, PH_SCALE:         state_d = ST_EL_RD;
					default:                    state_d = want_q ? ST_RD : ST_IDLE;
				endcase
			end
			ST_CP_RD:  state_d = ST_CP_WR;
			ST_CP_WR:  state_d = cnt_last ? ST_DISPATCH : ST_CP_RD;
			ST_BF_RD0: state_d = ST_BF_RD1;
			ST_BF_RD1: state_d = ST_BF_RD2;
			ST_BF_RD2: state_d = ST_BF_MUL;
			ST_BF_MUL: state_d = ST_WAIT;
			ST_BF_WR0: state_d = ST_BF_WR1;
			ST_BF_WR1: state_d = bf_last ? ST_DISPATCH : ST_BF_RD0;
			ST_EL_RD:  state_d = ST_EL_CAP;
			ST_EL_CAP: state_d = ST_EL_MUL;
			ST_EL_MUL: state_d = ST_WAIT;
			ST_EL_WR:  state_d = cnt_last ? ST_DISPATCH : ST_EL_RD;
			ST_RD:     state_d = ST_CAP;
			ST_CAP:    state_d = sts.out_busy ? ST_CAP : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd        = '0;
		cmd.wsrc   = WS_COEFF;
		cmd.mul_op = MUL_FWD;
		cmd.use_t  = (phase_q == PH_FWD_T);
		cmd.neg_z  = !fwd;
		cmd.z_addr = m_idx;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_INIT_WR: begin
				cmd.z_addr = bitrev8(cnt_q);
				cmd.z_we   = 1'b1;
				cmd.mul_op = MUL_TWID;
			end
			ST_WAIT:    cmd.cap_r = (wait_q == 2'd3);
			ST_INIT_LD: cmd.pw_load = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			ST_WRITE: begin
				cmd.addr = idx_q;
				cmd.a_we = (kind_q == K_WRITE_A);
				cmd.b_we = (kind_q == K_WRITE_B);
			end
			ST_CP_RD: cmd.addr = cnt_q;
			ST_CP_WR: begin
				cmd.addr = cnt_q;
				cmd.t_we = 1'b1;
				cmd.wsrc = WS_COPY;
			end
			ST_BF_RD0: cmd.addr = j_lo;
			ST_BF_RD1: begin
				cmd.addr  = j_hi;
				cmd.cap_x = 1'b1;
				cmd.cap_z = 1'b1;
			end
			ST_BF_RD2: begin
				cmd.addr  = j_hi;
				cmd.cap_y = 1'b1;
			end
			ST_BF_MUL: begin
				// inverse butterfly writes the sum while the product is in flight
				cmd.addr   = j_lo;
				cmd.mul_op = fwd ? MUL_FWD : MUL_INV;
				cmd.wsrc   = WS_ADD_XY;
				cmd.a_we   = !fwd && !cmd.use_t;
				cmd.t_we   = !fwd && cmd.use_t;
			end
			ST_BF_WR0: begin
				cmd.addr = j_hi;
				cmd.wsrc = fwd ? WS_SUB_XR : WS_PROD;
				cmd.a_we = !cmd.use_t;
				cmd.t_we = cmd.use_t;
			end
			ST_BF_WR1: begin
				cmd.addr = j_lo;
				cmd.wsrc = WS_ADD_XR;
				cmd.a_we = fwd && !cmd.use_t;
				cmd.t_we = fwd && cmd.use_t;
			end
			ST_EL_RD: cmd.addr = cnt_q;
			ST_EL_CAP: begin
				cmd.addr     = cnt_q;
				cmd.cap_pair = 1'b1;
			end
			ST_EL_MUL: cmd.mul_op = (phase_q == PH_POINT) ? MUL_POINT : MUL_SCALE;
			ST_EL_WR: begin
				cmd.addr = cnt_q;
				cmd.a_we = 1'b1;
				cmd.wsrc = WS_PROD;
			end
			ST_RD: cmd.addr = idx_q;
			ST_CAP: begin
				cmd.addr     = idx_q;
				cmd.out_load = !sts.out_busy;
			end
			default: cmd.addr = idx_q;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_WR;
			phase_q <= PH_START;
			kind_q  <= K_WRITE_A;
			idx_q   <= '0;
			want_q  <= 1'b0;
			lyr_q   <= '0;
			bf_q    <= '0;
			cnt_q   <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_INIT_WR, ST_BF_MUL, ST_EL_MUL: wait_q <= '0;
				ST_WAIT:    wait_q <= wait_q + 2'd1;
				ST_INIT_LD: cnt_q <= cnt_q + ADDR_W'(1);
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind_t'(in_kind);
						idx_q   <= in_index;
						want_q  <= in_want;
						phase_q <= next_phase(kind_t'(in_kind), PH_START);
					end
				end
				ST_DISPATCH: begin
					lyr_q <= '0;
					bf_q  <= '0;
					cnt_q <= '0;
				end
				ST_CP_WR, ST_EL_WR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_last) begin
						phase_q <= next_phase(kind_q, phase_q);
					end
				end
				ST_BF_WR1: begin
					bf_q <= bf_q + 7'd1;
					if (bf_q == 7'd127) begin
						lyr_q <= lyr_q + 3'd1;
						if (lyr_q == 3'd7) begin
							phase_q <= next_phase(kind_q, phase_q);
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== src/ntt_poly_multiplier.sv =====
// Top level of the ML-DSA NTT polynomial multiplier (q = 8380417, 256 coefficients).
//
//  channel | dir | payload                              | handshake
//  cmd     | in  | kind, index, coeff, want_read        | valid/ready
//  rsp     | out | read_value                           | valid/ready
//
// A write passes through ST_WRITE; a read-back word adds ST_RD and ST_CAP.
// A transform is 1024 butterflies, one after another (one RAM read port, 4-stage
// modular multiplier); the inverse adds a scaling pass over all 256 coefficients.
// A*B copies B into T, runs three transforms, a pointwise product and scaling.
// After reset a 256-step twiddle sweep runs with cmd.ready low.
// A pending rsp word does not stop new commands; only a second read-back waits for it.
module ntt_poly_multiplier (
	input logic           clk,
	input logic           arst_n,
	npm_in_if.sink        cmd,
	npm_out_if.source     rsp
);
	import npm_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	npm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd.valid), .in_ready(cmd.ready),
		.in_kind(cmd.kind), .in_index(cmd.index), .in_want(cmd.want_read),
		.sts(dp_sts), .cmd(dp_cmd));

	npm_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(dp_cmd), .sts(dp_sts), .in_coeff(cmd.coeff),
		.out_ready(rsp.ready), .out_valid(rsp.valid), .out_value(rsp.read_value));
endmodule

// ===== src/npm_checker.sv =====
// Port-level checks for the NTT polynomial multiplier, bound to the top level.
module npm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [npm_pkg::COEFF_W-1:0] rsp_value
);
	import npm_pkg::*;

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("rsp word changed under stall");

	// results are fully reduced
	a_rsp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_value < MOD_Q)
		else $error("rsp value not below q");

	// cmd.ready is low in the cycle after a command is accepted
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd accepted back to back");

	// a result word appears only while a command is being finished
	a_rsp_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("rsp word without a command in progress");
endmodule

bind ntt_poly_multiplier npm_checker u_npm_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.read_value));

// ===== tb/ntt_poly_multiplier_checker.sv =====
// Checker: mirrors the two polynomials, predicts read-back words and compares them.
module ntt_poly_multiplier_checker (
	input  logic clk,
	npm_in_if    cmd,
	npm_out_if   rsp,
	output int   errors,
	output int   pending,
	output int   words_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import npm_pkg::*;

	logic [COEFF_W-1:0] poly_a[N_COEFFS];
	logic [COEFF_W-1:0] poly_b[N_COEFFS];
	logic [COEFF_W-1:0] zeta[N_COEFFS];
	logic [COEFF_W-1:0] expected_reads[$];

	function automatic logic [COEFF_W-1:0] mulq(input logic [COEFF_W-1:0] x,
		input logic [COEFF_W-1:0] y);
		logic [63:0] p;
		p = 64'(x) * 64'(y);
		return COEFF_W'(p % 64'(MOD_Q));
	endfunction

	function automatic logic [COEFF_W-1:0] addq(input logic [COEFF_W-1:0] x,
		input logic [COEFF_W-1:0] y);
		logic [31:0] s;
		s = 32'(x) + 32'(y);
		if (s >= 32'(MOD_Q))
			s = s - 32'(MOD_Q);
		return COEFF_W'(s);
	endfunction

	function automatic logic [COEFF_W-1:0] subq(input logic [COEFF_W-1:0] x,
		input logic [COEFF_W-1:0] y);
		return addq(x, COEFF_W'(32'(MOD_Q) - 32'(y)) == MOD_Q ? '0 : COEFF_W'(32'(MOD_Q) - 32'(y)));
	endfunction

	// twiddles: powers of the root, in bit-reversed index order
	initial begin
		logic [COEFF_W-1:0] pw[N_COEFFS];
		int r;
		pw[0] = 1;
		for (int k = 1; k < N_COEFFS; k++)
			pw[k] = mulq(pw[k-1], ROOT);
		for (int k = 0; k < N_COEFFS; k++) begin
			r = 0;
			for (int i = 0; i < ADDR_W; i++)
				r = (r << 1) | ((k >> i) & 1);
			zeta[k] = pw[r];
		end
		for (int k = 0; k < N_COEFFS; k++) begin
			poly_a[k] = '0;
			poly_b[k] = '0;
		end
	end

	task automatic forward_transform(inout logic [COEFF_W-1:0] w[N_COEFFS]);
		int m;
		logic [COEFF_W-1:0] z, t;
		m = 0;
		for (int len = N_COEFFS / 2; len >= 1; len = len / 2) begin
			for (int st = 0; st < N_COEFFS; st += 2 * len) begin
				m++;
				z = zeta[m % N_COEFFS];
				for (int j = st; j < st + len; j++) begin
					t = mulq(z, w[j+len]);
					w[j+len] = subq(w[j], t);
					w[j] = addq(w[j], t);
				end
			end
		end
	endtask

	task automatic inverse_transform(inout logic [COEFF_W-1:0] w[N_COEFFS]);
		int m;
		logic [COEFF_W-1:0] z, t, d;
		m = N_COEFFS;
		for (int len = 1; len < N_COEFFS; len = len * 2) begin
			for (int st = 0; st < N_COEFFS; st += 2 * len) begin
				m--;
				z = subq('0, zeta[m % N_COEFFS]);
				for (int j = st; j < st + len; j++) begin
					t = w[j];
					d = subq(t, w[j+len]);
					w[j] = addq(t, w[j+len]);
					w[j+len] = mulq(z, d);
				end
			end
		end
		for (int j = 0; j < N_COEFFS; j++)
			w[j] = mulq(w[j], INV_DEGREE);
	endtask

	// negacyclic product A*B via the transform domain
	task automatic product_into_a();
		logic [COEFF_W-1:0] tb_copy[N_COEFFS];
		tb_copy = poly_b;
		forward_transform(poly_a);
		forward_transform(tb_copy);
		for (int i = 0; i < N_COEFFS; i++)
			poly_a[i] = mulq(poly_a[i], tb_copy[i]);
		inverse_transform(poly_a);
	endtask

	initial begin
		errors = 0;
		pending = 0;
		words_checked = 0;
	end

	// command side: update the mirror, queue a read-back word
	always @(posedge clk) begin
		logic [COEFF_W-1:0] c;
		if (cmd.valid && cmd.ready) begin
			c = cmd.coeff;
			if (c >= MOD_Q)
				c = c - MOD_Q;
			case (cmd.kind)
				K_WRITE_A:  poly_a[cmd.index] = c;
				K_WRITE_B:  poly_b[cmd.index] = c;
				K_FWD_NTT:  forward_transform(poly_a);
				K_INV_NTT:  inverse_transform(poly_a);
				K_POLY_MUL: product_into_a();
				default:    ;
			endcase
			if (cmd.want_read)
				expected_reads.push_back(poly_a[cmd.index]);
		end
		// result side: oldest expectation first
		if (rsp.valid && rsp.ready) begin
			if (expected_reads.size() == 0) begin
				$display("%0t: unexpected read word %0d", $time, rsp.read_value);
				errors++;
			end else begin
				c = expected_reads.pop_front();
				words_checked++;
				if (rsp.read_value !== c) begin
					$display("%0t: read_value mismatch: expected %0d, actual %0d",
						$time, c, rsp.read_value);
					errors++;
				end
			end
		end
		pending = expected_reads.size();
	end
endmodule

// ===== tb/ntt_poly_multiplier_tb.sv =====
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module ntt_poly_multiplier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import npm_pkg::*;

	localparam int          STALL_LIMIT  = 200000;
	localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
	localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
	localparam logic [22:0] COEFF_ALL_ONES = 23'h7FFFFF;

	logic clk = 0;
	logic arst_n = 0;

	npm_in_if  cmd();
	npm_out_if rsp();

	int errors, pending, words_checked;
	int idle_cycles = 0;
	int sent = 0;
	bit cmd_burst = 0;
	bit rsp_burst = 0;
	int rsp_stall = 0;
	bit a_written[N_COEFFS];
	int transforms = 0;

	ntt_poly_multiplier dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	ntt_poly_multiplier_checker chk (
		.clk(clk), .cmd(cmd), .rsp(rsp),
		.errors(errors), .pending(pending), .words_checked(words_checked)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		cmd.valid = 0;
		cmd.kind = '0;
		cmd.index = '0;
		cmd.coeff = '0;
		cmd.want_read = 0;
		rsp.ready = 0;
	end

	// result back-pressure: a random stall after each word, none in burst mode
	always @(posedge clk or negedge arst_n) begin
		int nxt;
		if (!arst_n) begin
			rsp.ready <= 0;
			rsp_stall = 0;
		end else begin
			nxt = rsp_stall;
			if (rsp.valid && rsp.ready)
				nxt = rsp_burst ? 0 : $urandom_range(0, 8);
			else if (nxt > 0)
				nxt--;
			rsp_stall = nxt;
			rsp.ready <= (nxt == 0);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_cmd(input logic [2:0] kind, input int idx,
		input logic [22:0] coeff, input bit want);
		int gap;
		gap = cmd_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			cmd.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1;
		cmd.kind <= kind;
		cmd.index <= idx[7:0];
		cmd.coeff <= coeff;
		cmd.want_read <= want;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		if (kind == K_WRITE_A)
			a_written[idx] = 1;
		if (kind == K_FWD_NTT || kind == K_INV_NTT || kind == K_POLY_MUL)
			transforms++;
		sent++;
		if (sent % 48 == 0) begin
			cmd_burst = !cmd_burst;
			rsp_burst = ($urandom_range(0, 2) == 0);
		end
	endtask

	function automatic logic [22:0] rand_coeff();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MOD_Q - 1;
			2: return COEFF_ALL_ONES;
			3: return 23'($urandom_range(MOD_Q, COEFF_ALL_ONES));
			default: return 23'($urandom);
		endcase
	endfunction

	// a read of A is only requested at an index that holds a written value
	function automatic int written_index();
		int i;
		i = $urandom_range(0, N_COEFFS - 1);
		while (!a_written[i])
			i = (i + 1) % N_COEFFS;
		return i;
	endfunction

	initial begin
		int k, idx;
		foreach (a_written[i])
			a_written[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes, reduction of values at or above q, spare kinds
		send_cmd(K_WRITE_A, 0, '0, 1);
		send_cmd(K_WRITE_A, 255, MOD_Q - 1, 1);
		send_cmd(K_WRITE_A, 1, MOD_Q, 1);
		send_cmd(K_WRITE_A, 2, COEFF_ALL_ONES, 1);
		send_cmd(K_WRITE_A, 170, 23'h2AAAAA, 1);
		send_cmd(K_WRITE_A, 85, 23'h555555, 0);
		send_cmd(K_WRITE_B, 0, MOD_Q - 1, 0);
		send_cmd(K_WRITE_B, 255, COEFF_ALL_ONES, 1);
		for (logic [3:0] s = KIND_SPARE_LO; s <= KIND_SPARE_HI; s++)
			send_cmd(s[2:0], 255, COEFF_ALL_ONES, 1);
		send_cmd(K_WRITE_A, 85, '0, 1);

		// fill both polynomials with random content, some reads in between
		for (int i = 0; i < N_COEFFS; i++) begin
			if (!a_written[i])
				send_cmd(K_WRITE_A, i, rand_coeff(), $urandom_range(0, 3) == 0);
			if (i != 0 && i != 255)
				send_cmd(K_WRITE_B, i, rand_coeff(), $urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0)
				send_cmd(KIND_SPARE_LO, written_index(), 23'($urandom), 1);
		end

		// every transform once with read-back, then a forward transform without
		send_cmd(K_FWD_NTT, 0, '0, 1);
		send_cmd(K_INV_NTT, 255, '0, 1);
		send_cmd(K_POLY_MUL, 128, '0, 1);
		send_cmd(K_FWD_NTT, 7, '0, 0);

		// random mix over the fully written state
		for (int n = 0; n < 70; n++) begin
			k = $urandom_range(0, 99);
			idx = $urandom_range(0, N_COEFFS - 1);
			if (k < 38)
				send_cmd(K_WRITE_A, idx, rand_coeff(), $urandom_range(0, 1));
			else if (k < 62)
				send_cmd(K_WRITE_B, idx, rand_coeff(), $urandom_range(0, 1));
			else if (k < 70)
				send_cmd(K_FWD_NTT, idx, 23'($urandom), $urandom_range(0, 1));
			else if (k < 78)
				send_cmd(K_INV_NTT, idx, 23'($urandom), $urandom_range(0, 1));
			else if (k < 83)
				send_cmd(K_POLY_MUL, idx, 23'($urandom), $urandom_range(0, 1));
			else
				send_cmd(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), idx,
					23'($urandom), 1);
		end
		cmd.valid <= 0;

		// drain outstanding read-backs, then let the block settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d commands (%0d transforms or products), checked %0d read words.",
			sent, transforms, words_checked);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
